>>> design/pllt_pkg.sv
// Package for the piecewise-linear table lookup unit.
// Holds widths, command codes, the controller state type and the search token record.
// No dependencies.
package pllt_pkg;

   localparam int MAX_POINTS_DEF = 32;
   localparam int COORD_W        = 16;
   localparam int CNT_W          = 6;
   localparam int IDX_W          = 5;
   localparam int PROD_W         = 2 * COORD_W;
   localparam int NUM_W          = PROD_W + 1;
   localparam int STEP_W         = 4;
   localparam int EXT_W          = 9;

   localparam logic             CMD_WRITE   = 1'b0;
   localparam logic             CMD_QUERY   = 1'b1;
   localparam logic [CNT_W-1:0] COUNT_RESET = 6'd2;
   localparam logic [EXT_W-1:0] MIN_POINTS  = 9'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SUM,
      ST_DIV,
      ST_FIN
   } state_type;

   // Record that walks the cell chain with one query.
   typedef struct packed {
      logic               active;
      logic [COORD_W-1:0] q;
      logic [COORD_W-1:0] first_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] prev_x;
      logic [COORD_W-1:0] prev_y;
      logic [COORD_W-1:0] last_x;
      logic [COORD_W-1:0] last_y;
      logic               found;
      logic               zero;
      logic [COORD_W-1:0] ya;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] y2;
   } token_type;

endpackage

>>> design/pllt_if.sv
// Request and response channel interfaces of the lookup unit.
// Depends on pllt_pkg for the field widths.
interface pllt_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [pllt_pkg::IDX_W-1:0]       point_index;
   logic [pllt_pkg::COORD_W-1:0]     point_x;
   logic [pllt_pkg::COORD_W-1:0]     point_y;
   logic [pllt_pkg::COORD_W-1:0]     query_value;

   modport source (output valid, command, point_index, point_x, point_y, query_value,
                   input ready);
   modport sink   (input valid, command, point_index, point_x, point_y, query_value,
                   output ready);
endinterface

interface pllt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pllt_pkg::COORD_W-1:0]     result_value;
   logic                             clamped;

   modport source (output valid, result_value, clamped, input ready);
   modport sink   (input valid, result_value, clamped, output ready);
endinterface

>>> design/pllt_cell.sv
// One breakpoint cell of the search chain: stores a point and, past cell 0, tests one segment.
// Depends on pllt_pkg for the token record.
module pllt_cell #(
   parameter int IDX = 0,
   parameter int UW  = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [pllt_pkg::COORD_W-1:0] wr_x,
   input  logic [pllt_pkg::COORD_W-1:0] wr_y,
   input  logic [UW-1:0]                n_used,
   input  pllt_pkg::token_type          tok_in,
   output pllt_pkg::token_type          tok_out
);

   localparam logic [UW-1:0] IDX_U  = UW'(IDX);
   localparam logic [UW-1:0] IDX_U1 = UW'(IDX + 1);

   logic [pllt_pkg::COORD_W-1:0] x_ff;
   logic [pllt_pkg::COORD_W-1:0] y_ff;
   pllt_pkg::token_type          tok_ff;
   pllt_pkg::token_type          tok_in_c;
   logic                         hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_ff <= wr_x;
         y_ff <= wr_y;
      end
   end

   always_comb begin
      tok_in_c = tok_in;
      hit = ((tok_in.q >= tok_in.prev_x) && (tok_in.q <= x_ff)) ||
            ((tok_in.q <= tok_in.prev_x) && (tok_in.q >= x_ff));
      if (IDX == 0) begin
         tok_in_c.first_x = x_ff;
         tok_in_c.first_y = y_ff;
      end else if (tok_in.active && !tok_in.found && (IDX_U < n_used) && hit) begin
         tok_in_c.found = 1'b1;
         tok_in_c.ya    = tok_in.prev_y;
         if (x_ff < tok_in.prev_x) begin
            tok_in_c.x1 = x_ff;
            tok_in_c.x2 = tok_in.prev_x;
            tok_in_c.y1 = y_ff;
            tok_in_c.y2 = tok_in.prev_y;
         end else begin
            tok_in_c.x1 = tok_in.prev_x;
            tok_in_c.x2 = x_ff;
            tok_in_c.y1 = tok_in.prev_y;
            tok_in_c.y2 = y_ff;
         end
         tok_in_c.zero = (x_ff == tok_in.prev_x);
      end
      if (IDX_U1 == n_used) begin
         tok_in_c.last_x = x_ff;
         tok_in_c.last_y = y_ff;
      end
      tok_in_c.prev_x = x_ff;
      tok_in_c.prev_y = y_ff;
   end

   // Only the active flag is reset; the payload follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in_c.active;
      end
      tok_ff.q       <= tok_in_c.q;
      tok_ff.first_x <= tok_in_c.first_x;
      tok_ff.first_y <= tok_in_c.first_y;
      tok_ff.prev_x  <= tok_in_c.prev_x;
      tok_ff.prev_y  <= tok_in_c.prev_y;
      tok_ff.last_x  <= tok_in_c.last_x;
      tok_ff.last_y  <= tok_in_c.last_y;
      tok_ff.found   <= tok_in_c.found;
      tok_ff.zero    <= tok_in_c.zero;
      tok_ff.ya      <= tok_in_c.ya;
      tok_ff.x1      <= tok_in_c.x1;
      tok_ff.x2      <= tok_in_c.x2;
      tok_ff.y1      <= tok_in_c.y1;
      tok_ff.y2      <= tok_in_c.y2;
   end

   assign tok_out = tok_ff;

endmodule

>>> design/pllt_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit 16 bits.
// Depends on pllt_pkg for widths.
module pllt_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pllt_pkg::NUM_W-1:0]   num,
   input  logic [pllt_pkg::COORD_W-1:0] den,
   output logic [pllt_pkg::COORD_W-1:0] quo,
   output logic                         valid
);

   logic [pllt_pkg::NUM_W-1:0]   rem_ff,  rem_in;
   logic [pllt_pkg::NUM_W-1:0]   dsr_ff,  dsr_in;
   logic [pllt_pkg::COORD_W-1:0] quo_ff,  quo_in;
   logic [pllt_pkg::STEP_W-1:0]  cnt_ff,  cnt_in;
   logic                         busy_ff, busy_in;
   logic                         valid_ff, valid_in;

   always_comb begin
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      if (start) begin
         rem_in   = num;
         dsr_in   = {2'b00, den, {(pllt_pkg::COORD_W - 1){1'b0}}};
         cnt_in   = '0;
         busy_in  = 1'b1;
         valid_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = {quo_ff[pllt_pkg::COORD_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[pllt_pkg::COORD_W-2:0], 1'b0};
         end
         dsr_in = dsr_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {pllt_pkg::STEP_W{1'b1}}) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign quo   = quo_ff;
   assign valid = valid_ff;

`ifndef SYNTHESIS
   a_valid_after_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == {pllt_pkg::STEP_W{1'b1}}) |=> valid_ff)
      else $error("divider did not finish after its last step");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && valid_ff))
      else $error("divider busy and valid at once");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && !valid_ff))
      else $error("divider start not taken");
`endif

endmodule

>>> design/piecewise_linear_table_lookup_unit.sv
// Top level of the piecewise-linear table lookup unit: cell chain, controller, output register.
// Depends on pllt_pkg, pllt_if, pllt_cell and pllt_div.
//
//   Port        Dir   Handshake          Moves
//   req_chan    in    valid/ready        write-point or query request
//   rsp_chan    out   valid/ready        interpolated value and clamp flag
//   csr_wr_*    in    write enable only  point_count register
//
// A write request gives no response. A query walks MAX_POINTS cells, one per cycle;
// the sum state then starts the divider, the divide state waits for the quotient and
// the finish state loads the response register, after which the next request is taken.
// A clamp or zero-width segment goes from the walk straight to the finish state. Only the
// finish state stalls, while the response register is full. Reset is synchronous, active high.
module piecewise_linear_table_lookup_unit #(
   parameter int MAX_POINTS = pllt_pkg::MAX_POINTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   pllt_req_if.sink                   req_chan,
   pllt_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [pllt_pkg::CNT_W-1:0] csr_wr_data
);

   localparam int UW = $clog2(MAX_POINTS + 1);

   pllt_pkg::state_type          state_ff, state_in;
   logic [pllt_pkg::CNT_W-1:0]   point_count_ff;
   logic [pllt_pkg::EXT_W-1:0]   cnt_ext;
   logic [pllt_pkg::EXT_W-1:0]   used_ext;
   logic [UW-1:0]                n_used;

   pllt_pkg::token_type          chain [MAX_POINTS+1];
   pllt_pkg::token_type          tail;

   logic                         req_ready;
   logic                         req_fire;
   logic                         query_fire;
   logic                         write_fire;
   logic                         out_free;
   logic                         out_load;
   logic                         div_start;
   logic                         div_valid;
   logic [pllt_pkg::COORD_W-1:0] div_quo;

   logic [pllt_pkg::PROD_W-1:0]  p1_ff, p2_ff;
   logic [pllt_pkg::COORD_W-1:0] den_ff;
   logic [pllt_pkg::COORD_W-1:0] res_ff, res_in;
   logic                         clamp_ff, clamp_in;
   logic [pllt_pkg::COORD_W-1:0] clamp_val;

   logic                         rsp_valid_ff;
   logic [pllt_pkg::COORD_W-1:0] rsp_value_ff;
   logic                         rsp_clamp_ff;

   // Count register; the usable count is pinned to the range 2 .. MAX_POINTS.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= pllt_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      cnt_ext = pllt_pkg::EXT_W'(point_count_ff);
      if (cnt_ext < pllt_pkg::MIN_POINTS) begin
         used_ext = pllt_pkg::MIN_POINTS;
      end else if (cnt_ext > pllt_pkg::EXT_W'(MAX_POINTS)) begin
         used_ext = pllt_pkg::EXT_W'(MAX_POINTS);
      end else begin
         used_ext = cnt_ext;
      end
   end
   assign n_used = used_ext[UW-1:0];

   assign req_fire   = req_chan.valid && req_ready;
   assign query_fire = req_fire && (req_chan.command == pllt_pkg::CMD_QUERY);
   assign write_fire = req_fire && (req_chan.command == pllt_pkg::CMD_WRITE);

   // The head token starts a query at cell 0; the cells fill in the rest as it passes.
   always_comb begin
      chain[0]        = '0;
      chain[0].active = query_fire;
      chain[0].q      = req_chan.query_value;
   end

   for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
      logic cell_wr;
      assign cell_wr = write_fire &&
         (pllt_pkg::EXT_W'(req_chan.point_index) == pllt_pkg::EXT_W'(j));
      pllt_cell #(
         .IDX (j),
         .UW  (UW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (cell_wr),
         .wr_x    (req_chan.point_x),
         .wr_y    (req_chan.point_y),
         .n_used  (n_used),
         .tok_in  (chain[j]),
         .tok_out (chain[j+1])
      );
   end

   assign tail = chain[MAX_POINTS];

   // End point chosen by the table's direction when no segment brackets the query.
   always_comb begin
      if (tail.first_x <= tail.last_x) begin
         clamp_val = (tail.q >= tail.last_x) ? tail.last_y : tail.first_y;
      end else begin
         clamp_val = (tail.q >= tail.first_x) ? tail.first_y : tail.last_y;
      end
   end

   pllt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (pllt_pkg::NUM_W'(p1_ff) + pllt_pkg::NUM_W'(p2_ff)),
      .den   (den_ff),
      .quo   (div_quo),
      .valid (div_valid)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pllt_pkg::ST_IDLE: begin
            if (query_fire) begin
               state_in = pllt_pkg::ST_WALK;
            end
         end
         pllt_pkg::ST_WALK: begin
            if (tail.active) begin
               state_in = (tail.found && !tail.zero) ? pllt_pkg::ST_SUM : pllt_pkg::ST_FIN;
            end
         end
         pllt_pkg::ST_SUM: state_in = pllt_pkg::ST_DIV;
         pllt_pkg::ST_DIV: begin
            if (div_valid) begin
               state_in = pllt_pkg::ST_FIN;
            end
         end
         pllt_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = pllt_pkg::ST_IDLE;
            end
         end
         default: state_in = pllt_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         pllt_pkg::ST_IDLE: req_ready = 1'b1;
         pllt_pkg::ST_WALK: ;
         pllt_pkg::ST_SUM:  div_start = 1'b1;
         pllt_pkg::ST_DIV:  ;
         pllt_pkg::ST_FIN:  out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pllt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result staging: direct values at the chain's end, the quotient after division.
   always_comb begin
      res_in   = res_ff;
      clamp_in = clamp_ff;
      if ((state_ff == pllt_pkg::ST_WALK) && tail.active) begin
         if (!tail.found) begin
            res_in   = clamp_val;
            clamp_in = 1'b1;
         end else begin
            res_in   = tail.ya;
            clamp_in = 1'b0;
         end
      end else if ((state_ff == pllt_pkg::ST_DIV) && div_valid) begin
         res_in = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      clamp_ff <= clamp_in;
      if ((state_ff == pllt_pkg::ST_WALK) && tail.active) begin
         p1_ff  <= pllt_pkg::PROD_W'(tail.y1) * pllt_pkg::PROD_W'(tail.x2 - tail.q);
         p2_ff  <= pllt_pkg::PROD_W'(tail.y2) * pllt_pkg::PROD_W'(tail.q - tail.x1);
         den_ff <= tail.x2 - tail.x1;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= res_ff;
         rsp_clamp_ff <= clamp_ff;
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.clamped      = rsp_clamp_ff;

`ifndef SYNTHESIS
   a_tail_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == pllt_pkg::ST_WALK))
      else $error("search token left the chain outside the walk state");
   a_query_starts_walk: assert property (@(posedge clock) disable iff (reset)
      query_fire |=> (state_ff == pllt_pkg::ST_WALK))
      else $error("accepted query did not start a walk");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == pllt_pkg::ST_FIN))
      else $error("response raised outside the finish state");
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (point_count_ff == $past(csr_wr_data)))
      else $error("point count write lost");
`endif

endmodule
